>>> rtl/frg_pkg.sv
// Shared types and constants for the fraction reducer.
`default_nettype none

package frg_pkg;

    // Magnitude width: inputs of -2^31 are rejected, so magnitudes fit 31 bits
    localparam int unsigned MAG_W = 31;
    localparam int unsigned CNT_W = $clog2(MAG_W);

    // Result kinds
    localparam logic [1:0] KIND_FRACTION  = 2'd0;
    localparam logic [1:0] KIND_INTEGER   = 2'd1;
    localparam logic [1:0] KIND_UNDEFINED = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_EUCLID,
        S_DIV_NUM,
        S_DIV_DEN,
        S_OUT
    } t_state;

    // Request into the shared divider
    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] dividend;
        logic [MAG_W-1:0] divisor;
    } t_div_req;

    // Response from the shared divider
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [MAG_W-1:0] quotient;
        logic [MAG_W-1:0] remainder;
    } t_div_rsp;

endpackage

`default_nettype wire

>>> rtl/frg_div_unit.sv
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module frg_div_unit (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire frg_pkg::t_div_req i_req,
    output frg_pkg::t_div_rsp o_rsp
);

    localparam int unsigned W = frg_pkg::MAG_W;
    localparam int unsigned C = frg_pkg::CNT_W;

    logic         r_busy, n_busy;
    logic         r_done, n_done;
    logic [C-1:0] r_cnt,  n_cnt;
    logic [W-1:0] r_rem,  n_rem;
    logic [W-1:0] r_quo,  n_quo;
    logic [W-1:0] r_dvs,  n_dvs;

    logic [W:0]   shifted;
    logic [W:0]   diff;
    logic         fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign shifted = {r_rem, r_quo[W-1]};
    assign diff    = shifted - {1'b0, r_dvs};
    assign fits    = (shifted >= {1'b0, r_dvs});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            n_rem = fits ? diff[W-1:0] : shifted[W-1:0];
            n_quo = {r_quo[W-2:0], fits};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == C'(W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_rsp.busy      = r_busy;
    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

`default_nettype wire

>>> rtl/fraction_reducer_gcd_core.sv
// Fraction reducer: Euclid's GCD on a shared serial divider, then reduction.
//
// Channel   Dir  Fields (low bit up)
// s_axis    in   tdata: numerator[31:0], denominator[63:32]; tlast: batch end
// m_axis    out  tdata: reduced numerator[31:0], reduced denominator[62:32],
//                zero[63]; tuser: result kind[1:0]; tlast: batch end
//
// Every division runs through one radix-2 divider. Undefined inputs skip
// the divider; an exact quotient needs one division; other fractions need
// the Euclid divisions, then one each for numerator and denominator.
// Euclid takes at most about 45 steps after the first for 31-bit magnitudes.
// One item at a time; a finished result waits in the output register while
// the next item is accepted. Synchronous active-low reset; no clearing pass.
`default_nettype none

module fraction_reducer_gcd_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [63:0] i_s_axis_tdata,   // numerator, denominator
    input  wire         i_s_axis_tlast,   // batch end
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // reduced numerator, reduced denominator
    output logic [1:0]  o_m_axis_tuser,   // result kind
    output logic        o_m_axis_tlast    // batch end
);

    localparam int unsigned W = frg_pkg::MAG_W;

    frg_pkg::t_state   r_state, n_state;
    frg_pkg::t_div_req div_req;
    frg_pkg::t_div_rsp div_rsp;

    logic [W-1:0] r_an,   n_an;
    logic [W-1:0] r_ad,   n_ad;
    logic [W-1:0] r_y,    n_y;
    logic         r_neg,  n_neg;
    logic         r_last, n_last;
    logic [1:0]   r_kind, n_kind;
    logic [W-1:0] r_rnum, n_rnum;
    logic [W-1:0] r_rden, n_rden;

    logic         r_ovalid, n_ovalid;
    logic [63:0]  r_odata,  n_odata;
    logic [1:0]   r_okind,  n_okind;
    logic         r_olast,  n_olast;

    logic [31:0]  in_num, in_den;
    logic [31:0]  abs_num, abs_den;
    logic         in_undef;
    logic         in_acc;
    logic         out_free;
    logic [31:0]  signed_num;

    assign in_num  = i_s_axis_tdata[31:0];
    assign in_den  = i_s_axis_tdata[63:32];
    assign abs_num = in_num[31] ? (32'd0 - in_num) : in_num;
    assign abs_den = in_den[31] ? (32'd0 - in_den) : in_den;
    assign in_undef = (in_den == 32'd0) || (in_num == 32'h8000_0000)
                   || (in_den == 32'h8000_0000);

    assign o_s_axis_tready = (r_state == frg_pkg::S_IDLE);
    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_ovalid || i_m_axis_tready;

    // Apply the result sign to the reduced magnitude
    assign signed_num = r_neg ? (32'd0 - {1'b0, r_rnum}) : {1'b0, r_rnum};

    frg_div_unit u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Sequencer: next state, divider requests, working registers
    always_comb begin
        n_state  = r_state;
        n_an     = r_an;
        n_ad     = r_ad;
        n_y      = r_y;
        n_neg    = r_neg;
        n_last   = r_last;
        n_kind   = r_kind;
        n_rnum   = r_rnum;
        n_rden   = r_rden;
        n_ovalid = r_ovalid;
        n_odata  = r_odata;
        n_okind  = r_okind;
        n_olast  = r_olast;
        div_req.start    = 1'b0;
        div_req.dividend = r_an;
        div_req.divisor  = r_ad;

        if (r_ovalid && i_m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            frg_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_last = i_s_axis_tlast;
                    if (in_undef) begin
                        n_kind  = frg_pkg::KIND_UNDEFINED;
                        n_rnum  = '0;
                        n_rden  = '0;
                        n_neg   = 1'b0;
                        n_state = frg_pkg::S_OUT;
                    end else begin
                        n_an  = abs_num[W-1:0];
                        n_ad  = abs_den[W-1:0];
                        n_neg = (in_num[31] ^ in_den[31]) && (abs_num != 32'd0);
                        div_req.start    = 1'b1;
                        div_req.dividend = abs_num[W-1:0];
                        div_req.divisor  = abs_den[W-1:0];
                        n_state = frg_pkg::S_FIRST;
                    end
                end
            end
            frg_pkg::S_FIRST: begin
                if (div_rsp.done) begin
                    if (div_rsp.remainder == '0) begin
                        // Denominator divides numerator: whole integer
                        n_kind  = frg_pkg::KIND_INTEGER;
                        n_rnum  = div_rsp.quotient;
                        n_rden  = W'(1);
                        n_state = frg_pkg::S_OUT;
                    end else begin
                        n_y = div_rsp.remainder;
                        div_req.start    = 1'b1;
                        div_req.dividend = r_ad;
                        div_req.divisor  = div_rsp.remainder;
                        n_state = frg_pkg::S_EUCLID;
                    end
                end
            end
            frg_pkg::S_EUCLID: begin
                if (div_rsp.done) begin
                    if (div_rsp.remainder == '0) begin
                        // r_y now holds the GCD
                        div_req.start    = 1'b1;
                        div_req.dividend = r_an;
                        div_req.divisor  = r_y;
                        n_state = frg_pkg::S_DIV_NUM;
                    end else begin
                        n_y = div_rsp.remainder;
                        div_req.start    = 1'b1;
                        div_req.dividend = r_y;
                        div_req.divisor  = div_rsp.remainder;
                    end
                end
            end
            frg_pkg::S_DIV_NUM: begin
                if (div_rsp.done) begin
                    n_rnum = div_rsp.quotient;
                    div_req.start    = 1'b1;
                    div_req.dividend = r_ad;
                    div_req.divisor  = r_y;
                    n_state = frg_pkg::S_DIV_DEN;
                end
            end
            frg_pkg::S_DIV_DEN: begin
                if (div_rsp.done) begin
                    n_rden  = div_rsp.quotient;
                    n_kind  = frg_pkg::KIND_FRACTION;
                    n_state = frg_pkg::S_OUT;
                end
            end
            frg_pkg::S_OUT: begin
                // Load the output register once it is free
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = {1'b0, r_rden, signed_num};
                    n_okind  = r_kind;
                    n_olast  = r_last;
                    n_state  = frg_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = frg_pkg::S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= frg_pkg::S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // Working and output payload registers
    always_ff @(posedge i_clk) begin
        r_an    <= n_an;
        r_ad    <= n_ad;
        r_y     <= n_y;
        r_neg   <= n_neg;
        r_last  <= n_last;
        r_kind  <= n_kind;
        r_rnum  <= n_rnum;
        r_rden  <= n_rden;
        r_odata <= n_odata;
        r_okind <= n_okind;
        r_olast <= n_olast;
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_okind;
    assign o_m_axis_tlast  = r_olast;

`ifndef SYNTHESIS
    // Divider is only started when it is free
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // Undefined results carry zero numerator and denominator
    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == frg_pkg::KIND_UNDEFINED))
        |-> (o_m_axis_tdata == 64'd0))
        else $error("undefined result with nonzero payload");

    // Whole integers have denominator one
    a_int_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == frg_pkg::KIND_INTEGER))
        |-> (o_m_axis_tdata[62:32] == 31'd1))
        else $error("integer result with denominator other than one");

    // Reduced fractions keep a denominator above one
    a_frac_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == frg_pkg::KIND_FRACTION))
        |-> (o_m_axis_tdata[62:32] > 31'd1))
        else $error("fraction result with denominator of one or less");
`endif

endmodule

`default_nettype wire
